FILE: hdl/arp_responder_cache_unit_macros.svh
// Assertion macros for the ARP responder cache unit.
// Used by the port checker; no other dependencies.
`ifndef ARP_RESPONDER_CACHE_UNIT_MACROS_SVH
`define ARP_RESPONDER_CACHE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ARC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ARC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/arc_pkg.sv
// Shared types, codes and beat layouts for the ARP responder cache unit.
// No dependencies; imported by arc_cache, the top level and the port checker.
`timescale 1ns / 1ps

package arc_pkg;

    localparam int CACHE_DEPTH_DEF = 16;

    // configuration port
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_ADDR_W     = 4;
    localparam int REG_DEVICE_MAC = 0;
    localparam int REG_DEVICE_IP  = 1;

    // frame checks
    localparam logic [10:0] MIN_FRAME_LEN    = 11'd42;
    localparam logic [15:0] HW_TYPE_ETH      = 16'h0001;
    localparam logic [15:0] PROTO_TYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  HW_ADDR_LEN_ETH  = 8'd6;
    localparam logic [7:0]  PROTO_ADDR_LEN_V4 = 8'd4;
    localparam logic [15:0] ARP_OPER_REQUEST = 16'd1;

    typedef enum logic [1:0] {
        OP_RX_FRAME = 2'd0,
        OP_RESOLVE  = 2'd1,
        OP_SEND_REQ = 2'd2,
        OP_UNUSED   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_REPLY   = 3'd1,
        KIND_REQUEST = 3'd2,
        KIND_HIT     = 3'd3,
        KIND_MISS    = 3'd4
    } kind_t;

    localparam logic [1:0] TX_OPER_NONE    = 2'd0;
    localparam logic [1:0] TX_OPER_REQUEST = 2'd1;
    localparam logic [1:0] TX_OPER_REPLY   = 2'd2;

    // input beat layout
    localparam int S_TUSER_W         = 2;
    localparam int S_FRAME_LEN_LSB   = 0;
    localparam int S_HW_TYPE_LSB     = 11;
    localparam int S_PROTO_TYPE_LSB  = 27;
    localparam int S_HW_ALEN_LSB     = 43;
    localparam int S_PROTO_ALEN_LSB  = 51;
    localparam int S_ARP_OPER_LSB    = 59;
    localparam int S_SMAC_LSB        = 75;
    localparam int S_SIP_LSB         = 123;
    localparam int S_TGT_IP_LSB      = 155;
    localparam int S_QIP_LSB         = 187;
    localparam int S_TDATA_W         = 224;

    // result beat layout
    localparam int M_TUSER_W     = 3;
    localparam int M_TX_OPER_LSB = 0;
    localparam int M_DEST_LSB    = 2;
    localparam int M_TMAC_LSB    = 50;
    localparam int M_TIP_LSB     = 98;
    localparam int M_RMAC_LSB    = 130;
    localparam int M_TDATA_W     = 184;

    typedef struct packed {
        logic        en;
        logic [31:0] ip;
        logic [47:0] mac;
    } cache_wr_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic        vld;
    } cache_rd_t;

endpackage

FILE: hdl/arc_slot.sv
// Cache slot unit: IPv4 address modulo cache depth, two register stages.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module arc_slot #(
    parameter int CACHE_DEPTH = 16,
    parameter int SLOT_W      = 4
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [31:0]       ip_in,
    output logic [SLOT_W-1:0] slot_out
);

    localparam int FOLD_W      = 18;
    localparam int RECIP_SHIFT = 18;
    localparam int PROD_W      = FOLD_W + RECIP_SHIFT + 1;
    localparam int REM_W       = 10;
    localparam int W0          = 1 % CACHE_DEPTH;
    localparam int W1          = 256 % CACHE_DEPTH;
    localparam int W2          = (W1 * 256) % CACHE_DEPTH;
    localparam int W3          = (W2 * 256) % CACHE_DEPTH;
    localparam int RECIP_M     = (2 ** RECIP_SHIFT) / CACHE_DEPTH;

    logic [FOLD_W-1:0] fold;
    logic [FOLD_W-1:0] x1_reg;
    logic [FOLD_W-1:0] x2_reg;
    logic [FOLD_W-1:0] q_reg;
    logic [FOLD_W-1:0] q_next;
    logic [PROD_W-1:0] prod;
    logic [FOLD_W-1:0] qd;
    logic [REM_W-1:0]  rem;
    logic [REM_W-1:0]  rem_fix;

    // fold bytes by their weights 256^i mod depth
    assign fold = FOLD_W'(ip_in[7:0])   * FOLD_W'(W0)
                + FOLD_W'(ip_in[15:8])  * FOLD_W'(W1)
                + FOLD_W'(ip_in[23:16]) * FOLD_W'(W2)
                + FOLD_W'(ip_in[31:24]) * FOLD_W'(W3);

    assign prod   = PROD_W'(x1_reg) * PROD_W'(RECIP_M);
    assign q_next = prod[RECIP_SHIFT +: FOLD_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg <= fold;
            x2_reg <= x1_reg;
            q_reg  <= q_next;
        end
    end

    // quotient estimate is low by at most one
    assign qd      = FOLD_W'(q_reg * FOLD_W'(CACHE_DEPTH));
    assign rem     = REM_W'(x2_reg - qd);
    assign rem_fix = (rem >= REM_W'(CACHE_DEPTH)) ? rem - REM_W'(CACHE_DEPTH) : rem;
    assign slot_out = SLOT_W'(rem_fix);

endmodule

FILE: hdl/arc_cache.sv
// Direct-mapped neighbor cache: IP and MAC memories, per-slot valid flops.
// Depends on arc_pkg for the read and write bundles.
`timescale 1ns / 1ps

module arc_cache #(
    parameter int CACHE_DEPTH = 16,
    parameter int SLOT_W      = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic [SLOT_W-1:0]   rd_slot,
    input  logic [SLOT_W-1:0]   wr_slot,
    input  arc_pkg::cache_wr_t  wr,
    output arc_pkg::cache_rd_t  rd
);

    import arc_pkg::*;

    logic [31:0]            ip_mem  [CACHE_DEPTH];
    logic [47:0]            mac_mem [CACHE_DEPTH];
    logic [CACHE_DEPTH-1:0] vld_reg;
    cache_rd_t              rd_reg;
    logic                   byp;

    assign byp = wr.en && (wr_slot == rd_slot);

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            ip_mem[wr_slot]  <= wr.ip;
            mac_mem[wr_slot] <= wr.mac;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr.en) begin
            vld_reg[wr_slot] <= 1'b1;
        end
    end

    // forward the entry written in this same beat
    always_ff @(posedge aclk) begin
        if (en) begin
            if (byp) begin
                rd_reg <= '{ip: wr.ip, mac: wr.mac, vld: 1'b1};
            end else begin
                rd_reg <= '{ip: ip_mem[rd_slot], mac: mac_mem[rd_slot], vld: vld_reg[rd_slot]};
            end
        end
    end

    assign rd = rd_reg;

endmodule

FILE: hdl/arp_responder_cache_unit.sv
// ARP responder cache unit, top level: stream in/out, APB registers, pipeline.
// Depends on arc_pkg, arc_slot and arc_cache.
//
//   channel   dir  ports                        beat content
//   s_        in   s_tvalid/tready/tdata/tuser  command or received ARP frame
//   m_        out  m_tvalid/tready/tdata/tuser  one result per command
//   apb       in   psel/penable/pwrite/paddr    device_mac at 0x0, device_ip at 0x8
//
// One beat per cycle sustained while the result beat is not stalled.
// The pipeline is the slot divider (two stages), the cache read and the result register.
// All stages hold together while the result beat is stalled; s_tready follows that.
// Reset clears the cache valid flops, registers and pipeline valids at once.
`timescale 1ns / 1ps

module arp_responder_cache_unit #(
    parameter int CACHE_DEPTH = arc_pkg::CACHE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // frame_len, hw_type, proto_type, hw_addr_len, proto_addr_len, arp_oper,
    // sender_mac, sender_ip, target_ip, query_ip, zero pad
    input  logic [arc_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode
    input  logic [arc_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tx_oper, eth_dest_mac, tx_target_mac, tx_target_ip, resolved_mac, zero pad
    output logic [arc_pkg::M_TDATA_W-1:0]   m_tdata,
    // result_kind
    output logic [arc_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [arc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [arc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [arc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    import arc_pkg::*;

    localparam int SLOT_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

    typedef struct packed {
        opcode_t     op;
        logic        frame_ok;
        logic        is_req;
        logic [47:0] smac;
        logic [31:0] tgt;
        logic [31:0] key_ip;
    } stage_t;

    logic [47:0]          dev_mac_reg;
    logic [31:0]          dev_ip_reg;
    logic                 cfg_wr;
    logic                 cfg_idx;

    logic                 adv;
    logic                 vld1_reg, vld2_reg, vld3_reg;
    stage_t               st_next, st1_reg, st2_reg, st3_reg;
    logic [SLOT_W-1:0]    slot;
    logic [SLOT_W-1:0]    slot3_reg;
    cache_wr_t            cwr;
    cache_rd_t            crd;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg;
    kind_t                kind_next;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_mac_reg <= '0;
            dev_ip_reg  <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                1'(REG_DEVICE_MAC): dev_mac_reg <= pwdata[47:0];
                1'(REG_DEVICE_IP):  dev_ip_reg  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            1'(REG_DEVICE_MAC): prdata = {16'd0, dev_mac_reg};
            1'(REG_DEVICE_IP):  prdata = {32'd0, dev_ip_reg};
            default:            prdata = '0;
        endcase
    end

    // input decode
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    always_comb begin
        st_next.op       = opcode_t'(s_tuser);
        st_next.frame_ok = (s_tdata[S_FRAME_LEN_LSB +: 11] >= MIN_FRAME_LEN)
                        && (s_tdata[S_HW_TYPE_LSB +: 16] == HW_TYPE_ETH)
                        && (s_tdata[S_PROTO_TYPE_LSB +: 16] == PROTO_TYPE_IPV4)
                        && (s_tdata[S_HW_ALEN_LSB +: 8] == HW_ADDR_LEN_ETH)
                        && (s_tdata[S_PROTO_ALEN_LSB +: 8] == PROTO_ADDR_LEN_V4);
        st_next.is_req   = (s_tdata[S_ARP_OPER_LSB +: 16] == ARP_OPER_REQUEST);
        st_next.smac     = s_tdata[S_SMAC_LSB +: 48];
        st_next.tgt      = s_tdata[S_TGT_IP_LSB +: 32];
        st_next.key_ip   = (st_next.op == OP_RX_FRAME) ? s_tdata[S_SIP_LSB +: 32]
                                                       : s_tdata[S_QIP_LSB +: 32];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg <= s_tvalid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_reg   <= st_next;
            st2_reg   <= st1_reg;
            st3_reg   <= st2_reg;
            slot3_reg <= slot;
        end
    end

    arc_slot #(
        .CACHE_DEPTH (CACHE_DEPTH),
        .SLOT_W      (SLOT_W)
    ) u_slot (
        .aclk     (aclk),
        .en       (adv),
        .ip_in    (st_next.key_ip),
        .slot_out (slot)
    );

    assign cwr.en  = adv && vld3_reg && (st3_reg.op == OP_RX_FRAME) && st3_reg.frame_ok;
    assign cwr.ip  = st3_reg.key_ip;
    assign cwr.mac = st3_reg.smac;

    arc_cache #(
        .CACHE_DEPTH (CACHE_DEPTH),
        .SLOT_W      (SLOT_W)
    ) u_cache (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .rd_slot (slot),
        .wr_slot (slot3_reg),
        .wr      (cwr),
        .rd      (crd)
    );

    // result
    always_comb begin
        kind_next    = KIND_NONE;
        m_tdata_next = '0;
        case (st3_reg.op)
            OP_RX_FRAME: begin
                if (st3_reg.frame_ok && st3_reg.is_req && (st3_reg.tgt == dev_ip_reg)) begin
                    kind_next                            = KIND_REPLY;
                    m_tdata_next[M_TX_OPER_LSB +: 2]     = TX_OPER_REPLY;
                    m_tdata_next[M_DEST_LSB +: 48]       = st3_reg.smac;
                    m_tdata_next[M_TMAC_LSB +: 48]       = st3_reg.smac;
                    m_tdata_next[M_TIP_LSB +: 32]        = st3_reg.key_ip;
                end
            end
            OP_RESOLVE: begin
                if (crd.vld && (crd.ip == st3_reg.key_ip)) begin
                    kind_next                        = KIND_HIT;
                    m_tdata_next[M_RMAC_LSB +: 48]   = crd.mac;
                end else begin
                    kind_next = KIND_MISS;
                end
            end
            OP_SEND_REQ: begin
                kind_next                        = KIND_REQUEST;
                m_tdata_next[M_TX_OPER_LSB +: 2] = TX_OPER_REQUEST;
                m_tdata_next[M_DEST_LSB +: 48]   = '1;
                m_tdata_next[M_TIP_LSB +: 32]    = st3_reg.key_ip;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= vld3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= kind_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: hdl/arc_checker.sv
// Port checker for the ARP responder cache unit, bound to the top level.
// Depends on arc_pkg and arp_responder_cache_unit_macros.svh.
`timescale 1ns / 1ps
`include "arp_responder_cache_unit_macros.svh"

module arc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [arc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [arc_pkg::M_TUSER_W-1:0] m_tuser
);

    import arc_pkg::*;

    `ARC_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    `ARC_ASSERT_NOW(a_kind_range, aclk, aresetn, m_tvalid, m_tuser <= 3'(KIND_MISS), "result kind out of range")

    `ARC_ASSERT_NOW(a_request_shape, aclk, aresetn, m_tvalid && (m_tuser == KIND_REQUEST), (m_tdata[M_TX_OPER_LSB +: 2] == TX_OPER_REQUEST) && (m_tdata[M_DEST_LSB +: 48] == 48'hFFFF_FFFF_FFFF) && (m_tdata[M_TMAC_LSB +: 48] == 48'd0) && (m_tdata[M_RMAC_LSB +: 48] == 48'd0), "malformed request beat")

    `ARC_ASSERT_NOW(a_no_frame_fields, aclk, aresetn, m_tvalid && ((m_tuser == KIND_NONE) || (m_tuser == KIND_HIT) || (m_tuser == KIND_MISS)), m_tdata[M_RMAC_LSB-1:0] == '0, "frame fields set without a frame")

endmodule

bind arp_responder_cache_unit arc_checker u_arc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
